@@ design/mspe_pkg.sv @@
// ----------------------------------------------------------------------------
// mspe_pkg : shared types and constants for the motor speed PID core
// Holds the microcode word layout, the microprogram, field widths and codes.
// ----------------------------------------------------------------------------
package mspe_pkg;

  // Fixed field widths
  localparam int REQ_W   = 2;
  localparam int CMD_W   = 8;
  localparam int DUTY_W  = 8;
  localparam int RPM_W   = 16;
  localparam int MS_W    = 10;
  localparam int PPR_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 16;
  localparam int DEN_W   = PPR_W + MS_W;
  localparam int ERR_W   = 18;
  localparam int MB_W    = 19;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_EDGE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CMD  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_PERIOD = 3'd0;
  localparam logic [CIDX_W-1:0] REG_PPR    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_GAIN_P = 3'd2;
  localparam logic [CIDX_W-1:0] REG_GAIN_I = 3'd3;
  localparam logic [CIDX_W-1:0] REG_GAIN_D = 3'd4;
  localparam logic [CIDX_W-1:0] REG_MIN_PWM = 3'd5;

  // Register reset values
  localparam logic [MS_W-1:0]   RST_PERIOD  = 10'd100;
  localparam logic [PPR_W-1:0]  RST_PPR     = 16'd11;
  localparam logic [GAIN_W-1:0] RST_GAIN_P  = 16'd973;
  localparam logic [GAIN_W-1:0] RST_GAIN_I  = 16'd84;
  localparam logic [GAIN_W-1:0] RST_GAIN_D  = 16'd44;
  localparam logic [DUTY_W-1:0] RST_MIN_PWM = 8'd50;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_DECODE,
    OP_MUL_CNT,
    OP_MUL_DEN,
    OP_LD_DEN,
    OP_DIV_SAT,
    OP_DIV_STEP,
    OP_SPEED,
    OP_ERR,
    OP_INT_DER,
    OP_MUL_I,
    OP_MUL_D,
    OP_ACC,
    OP_DUTY,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_PERIOD,
    C_DIV_SAT,
    C_CNT_NZ,
    C_OUT_BUSY
  } cond_t;

  localparam int UCODE_LEN = 14;
  localparam int STEP_W    = $clog2(UCODE_LEN);
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_START    = 4'd0;
  localparam step_t STEP_DIV_STEP = 4'd5;
  localparam step_t STEP_SPEED    = 4'd6;
  localparam step_t STEP_EMIT     = 4'd13;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  last;
  } ctrl_t;

  typedef struct packed {
    logic period_hit;
    logic div_sat;
    logic cnt_nz;
    logic out_busy;
  } stat_t;

  localparam ctrl_t UOP_IDLE = '{OP_NOP, C_NEVER, STEP_START, 1'b0};

  // Microprogram: one control word per step
  localparam ctrl_t UCODE [UCODE_LEN] = '{
    '{OP_DECODE,   C_NO_PERIOD, STEP_EMIT,     1'b0},
    '{OP_MUL_CNT,  C_NEVER,     STEP_START,    1'b0},
    '{OP_MUL_DEN,  C_NEVER,     STEP_START,    1'b0},
    '{OP_LD_DEN,   C_NEVER,     STEP_START,    1'b0},
    '{OP_DIV_SAT,  C_DIV_SAT,   STEP_SPEED,    1'b0},
    '{OP_DIV_STEP, C_CNT_NZ,    STEP_DIV_STEP, 1'b0},
    '{OP_SPEED,    C_NEVER,     STEP_START,    1'b0},
    '{OP_ERR,      C_NEVER,     STEP_START,    1'b0},
    '{OP_INT_DER,  C_NEVER,     STEP_START,    1'b0},
    '{OP_MUL_I,    C_NEVER,     STEP_START,    1'b0},
    '{OP_MUL_D,    C_NEVER,     STEP_START,    1'b0},
    '{OP_ACC,      C_NEVER,     STEP_START,    1'b0},
    '{OP_DUTY,     C_NEVER,     STEP_START,    1'b0},
    '{OP_EMIT,     C_OUT_BUSY,  STEP_EMIT,     1'b1}
  };

endpackage

@@ design/mspe_in_if.sv @@
// ----------------------------------------------------------------------------
// mspe_in_if : request channel
// Carries encoder edges, speed commands and millisecond ticks.
// ----------------------------------------------------------------------------
interface mspe_in_if;
  logic                                valid;
  logic                                ready;
  logic [mspe_pkg::REQ_W-1:0]          req_type;
  logic signed [mspe_pkg::CMD_W-1:0]   speed_cmd;

  modport source (output valid, req_type, speed_cmd, input ready);
  modport sink   (input valid, req_type, speed_cmd, output ready);
endinterface

@@ design/mspe_out_if.sv @@
// ----------------------------------------------------------------------------
// mspe_out_if : status channel
// Carries duty, direction lines, measured speed and the update flag.
// ----------------------------------------------------------------------------
interface mspe_out_if;
  logic                          valid;
  logic                          ready;
  logic [mspe_pkg::DUTY_W-1:0]   pwm_duty;
  logic                          dir_forward;
  logic                          dir_reverse;
  logic [mspe_pkg::RPM_W-1:0]    measured_rpm;
  logic                          loop_updated;

  modport source (output valid, pwm_duty, dir_forward, dir_reverse, measured_rpm,
                  loop_updated, input ready);
  modport sink   (input valid, pwm_duty, dir_forward, dir_reverse, measured_rpm,
                  loop_updated, output ready);
endinterface

@@ design/mspe_cfg_if.sv @@
// ----------------------------------------------------------------------------
// mspe_cfg_if : configuration write channel
// Carries a register index and write data.
// ----------------------------------------------------------------------------
interface mspe_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mspe_pkg::CIDX_W-1:0]   index;
  logic [mspe_pkg::CDAT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/mspe_seq.sv @@
// ----------------------------------------------------------------------------
// mspe_seq : microcode sequencer
// Step counter, control ROM fetch and conditional jump evaluation.
// ----------------------------------------------------------------------------
module mspe_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  mspe_pkg::stat_t stat,
  output mspe_pkg::ctrl_t uop,
  output logic            busy
);

  mspe_pkg::step_t pc_r, pc_nxt;
  logic            busy_r, busy_nxt;
  logic            jump;

  assign uop  = busy_r ? mspe_pkg::UCODE[pc_r] : mspe_pkg::UOP_IDLE;
  assign busy = busy_r;

  always_comb begin
    unique case (uop.cond)
      mspe_pkg::C_NEVER:     jump = 1'b0;
      mspe_pkg::C_NO_PERIOD: jump = !stat.period_hit;
      mspe_pkg::C_DIV_SAT:   jump = stat.div_sat;
      mspe_pkg::C_CNT_NZ:    jump = stat.cnt_nz;
      mspe_pkg::C_OUT_BUSY:  jump = stat.out_busy;
      default:               jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (start) begin
      pc_nxt   = mspe_pkg::STEP_START;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (jump) begin
        pc_nxt = uop.target;
      end else if (uop.last) begin
        pc_nxt   = mspe_pkg::STEP_START;
        busy_nxt = 1'b0;
      end else begin
        pc_nxt = pc_r + mspe_pkg::step_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= mspe_pkg::STEP_START;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

@@ design/mspe_dp.sv @@
// ----------------------------------------------------------------------------
// mspe_dp : datapath of the motor speed PID core
// Config registers, loop state, shared multiplier, divider and output register.
// ----------------------------------------------------------------------------
module mspe_dp #(
  parameter int COUNT_BITS    = 16,
  parameter int RPM_FRAC_BITS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [mspe_pkg::REQ_W-1:0]        in_req,
  input  logic signed [mspe_pkg::CMD_W-1:0] in_cmd,
  input  mspe_pkg::ctrl_t                   uop,
  output mspe_pkg::stat_t                   stat,
  mspe_cfg_if.sink                          cfg_ch,
  mspe_out_if.source                        out_ch
);

  localparam int MA_W    = (COUNT_BITS > mspe_pkg::GAIN_W) ? COUNT_BITS : mspe_pkg::GAIN_W;
  localparam int MB_W    = mspe_pkg::MB_W;
  localparam int P_W     = MA_W + MB_W + 1;
  localparam int ACC_W   = P_W + 2;
  localparam int NUM_W   = COUNT_BITS + 16 + RPM_FRAC_BITS;
  localparam int DSH_W   = mspe_pkg::DEN_W + mspe_pkg::RPM_W;
  localparam int CMP_W   = (NUM_W > DSH_W) ? NUM_W : DSH_W;
  localparam int ERR_W   = mspe_pkg::ERR_W;
  localparam int S_W     = ERR_W + 1;
  localparam int INT_LIM = 500 << RPM_FRAC_BITS;
  localparam int DER_LIM = 50 << RPM_FRAC_BITS;
  localparam int INT_W   = $clog2(INT_LIM + 1) + 1;
  localparam int DER_W   = $clog2(DER_LIM + 1) + 1;
  localparam int DSHIFT  = 8 + RPM_FRAC_BITS;

  localparam logic signed [S_W-1:0]  INT_HI    = S_W'(INT_LIM);
  localparam logic signed [S_W-1:0]  INT_LO    = -INT_HI;
  localparam logic signed [S_W-1:0]  DER_HI    = S_W'(DER_LIM);
  localparam logic signed [S_W-1:0]  DER_LO    = -DER_HI;
  localparam logic signed [MB_W-1:0] RPM_SCALE = MB_W'(60000);

  // Configuration
  logic [mspe_pkg::MS_W-1:0]   period_r, period_nxt;
  logic [mspe_pkg::PPR_W-1:0]  ppr_r, ppr_nxt;
  logic [mspe_pkg::GAIN_W-1:0] gain_p_r, gain_p_nxt, gain_i_r, gain_i_nxt;
  logic [mspe_pkg::GAIN_W-1:0] gain_d_r, gain_d_nxt;
  logic [mspe_pkg::DUTY_W-1:0] min_pwm_r, min_pwm_nxt;

  // Loop state
  logic [COUNT_BITS-1:0]         pulse_r, pulse_nxt;
  logic [mspe_pkg::MS_W-1:0]     ms_r, ms_nxt;
  logic [mspe_pkg::RPM_W-1:0]    speed_r, speed_nxt;
  logic signed [INT_W-1:0]       integral_r, integral_nxt;
  logic signed [ERR_W-1:0]       prev_r, prev_nxt;
  logic [mspe_pkg::DUTY_W-1:0]   duty_r, duty_nxt;
  logic [mspe_pkg::CMD_W-1:0]    target_r, target_nxt;
  mspe_pkg::dir_t                dir_r, dir_nxt;

  // Working registers
  logic [mspe_pkg::REQ_W-1:0]        req_r, req_nxt;
  logic signed [mspe_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic                              upd_r, upd_nxt;
  logic signed [P_W-1:0]             prod_r, prod_nxt;
  logic signed [ACC_W-1:0]           acc_r, acc_nxt;
  logic [NUM_W-1:0]                  rem_r, rem_nxt;
  logic [DSH_W-1:0]                  dsh_r, dsh_nxt;
  logic [mspe_pkg::RPM_W-1:0]        quo_r, quo_nxt;
  logic [3:0]                        cnt_r, cnt_nxt;
  logic signed [ERR_W-1:0]           err_r, err_nxt;
  logic signed [DER_W-1:0]           der_r, der_nxt;

  // Output register
  logic                          oval_r, oval_nxt;
  logic [mspe_pkg::DUTY_W-1:0]   opwm_r, opwm_nxt;
  logic                          ofwd_r, ofwd_nxt, orev_r, orev_nxt;
  logic [mspe_pkg::RPM_W-1:0]    orpm_r, orpm_nxt;
  logic                          oupd_r, oupd_nxt;

  // Combinational helpers
  logic [mspe_pkg::MS_W:0]       ms_inc;
  logic                          period_hit;
  logic                          div_ge;
  logic                          out_busy;
  logic                          cfg_wr;
  logic [MA_W-1:0]               mul_a;
  logic signed [MB_W-1:0]        mul_b;
  logic [mspe_pkg::PPR_W-1:0]    ppr_eff;
  logic [mspe_pkg::MS_W-1:0]     per_eff;
  logic signed [mspe_pkg::CMD_W:0] cmd_neg;
  logic [ERR_W-1:0]              tgt_sh;
  logic signed [S_W-1:0]         isum, iclamp, dsum, dclamp;
  logic [ACC_W-1:0]              mag, mag_sh;
  logic [mspe_pkg::DUTY_W-1:0]   duty_cap;

  assign ms_inc     = (mspe_pkg::MS_W+1)'(ms_r) + (mspe_pkg::MS_W+1)'(1);
  assign period_hit = (req_r == mspe_pkg::REQ_TICK) &&
                      (ms_inc >= (mspe_pkg::MS_W+1)'(period_r));
  assign div_ge     = CMP_W'(rem_r) >= CMP_W'(dsh_r);
  assign out_busy   = oval_r && !out_ch.ready;
  assign cfg_wr     = cfg_ch.valid && cfg_ch.ready;
  assign ppr_eff    = (ppr_r == '0) ? mspe_pkg::PPR_W'(1) : ppr_r;
  assign per_eff    = (period_r == '0) ? mspe_pkg::MS_W'(1) : period_r;
  assign cmd_neg    = -((mspe_pkg::CMD_W+1)'(cmd_r));

  assign stat.period_hit = period_hit;
  assign stat.div_sat    = div_ge;
  assign stat.cnt_nz     = (cnt_r != 4'd0);
  assign stat.out_busy   = out_busy;

  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = oval_r;
  assign out_ch.pwm_duty     = opwm_r;
  assign out_ch.dir_forward  = ofwd_r;
  assign out_ch.dir_reverse  = orev_r;
  assign out_ch.measured_rpm = orpm_r;
  assign out_ch.loop_updated = oupd_r;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (uop.op)
      mspe_pkg::OP_MUL_CNT: begin
        mul_a = MA_W'(pulse_r);
        mul_b = RPM_SCALE;
      end
      mspe_pkg::OP_MUL_DEN: begin
        mul_a = MA_W'(ppr_eff);
        mul_b = $signed(MB_W'(per_eff));
      end
      mspe_pkg::OP_INT_DER: begin
        mul_a = MA_W'(gain_p_r);
        mul_b = MB_W'(err_r);
      end
      mspe_pkg::OP_MUL_I: begin
        mul_a = MA_W'(gain_i_r);
        mul_b = MB_W'(integral_r);
      end
      mspe_pkg::OP_MUL_D: begin
        mul_a = MA_W'(gain_d_r);
        mul_b = MB_W'(der_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // PID arithmetic helpers
  always_comb begin
    tgt_sh = ERR_W'(target_r) << RPM_FRAC_BITS;
    isum   = S_W'(integral_r) + S_W'(err_r);
    dsum   = S_W'(err_r) - S_W'(prev_r);
    if (isum > INT_HI)      iclamp = INT_HI;
    else if (isum < INT_LO) iclamp = INT_LO;
    else                    iclamp = isum;
    if (dsum > DER_HI)      dclamp = DER_HI;
    else if (dsum < DER_LO) dclamp = DER_LO;
    else                    dclamp = dsum;
    mag    = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    mag_sh = mag >> DSHIFT;
    if (mag_sh > ACC_W'(255)) duty_cap = 8'hFF;
    else                      duty_cap = mag_sh[mspe_pkg::DUTY_W-1:0];
    if (duty_cap < min_pwm_r) duty_cap = min_pwm_r;
  end

  always_comb begin
    period_nxt   = period_r;
    ppr_nxt      = ppr_r;
    gain_p_nxt   = gain_p_r;
    gain_i_nxt   = gain_i_r;
    gain_d_nxt   = gain_d_r;
    min_pwm_nxt  = min_pwm_r;
    pulse_nxt    = pulse_r;
    ms_nxt       = ms_r;
    speed_nxt    = speed_r;
    integral_nxt = integral_r;
    prev_nxt     = prev_r;
    duty_nxt     = duty_r;
    target_nxt   = target_r;
    dir_nxt      = dir_r;
    req_nxt      = req_r;
    cmd_nxt      = cmd_r;
    upd_nxt      = upd_r;
    prod_nxt     = prod_r;
    acc_nxt      = acc_r;
    rem_nxt      = rem_r;
    dsh_nxt      = dsh_r;
    quo_nxt      = quo_r;
    cnt_nxt      = cnt_r;
    err_nxt      = err_r;
    der_nxt      = der_r;
    oval_nxt     = oval_r;
    opwm_nxt     = opwm_r;
    ofwd_nxt     = ofwd_r;
    orev_nxt     = orev_r;
    orpm_nxt     = orpm_r;
    oupd_nxt     = oupd_r;

    if (cfg_wr) begin
      unique case (cfg_ch.index)
        mspe_pkg::REG_PERIOD:  period_nxt  = cfg_ch.data[mspe_pkg::MS_W-1:0];
        mspe_pkg::REG_PPR:     ppr_nxt     = cfg_ch.data[mspe_pkg::PPR_W-1:0];
        mspe_pkg::REG_GAIN_P:  gain_p_nxt  = cfg_ch.data[mspe_pkg::GAIN_W-1:0];
        mspe_pkg::REG_GAIN_I:  gain_i_nxt  = cfg_ch.data[mspe_pkg::GAIN_W-1:0];
        mspe_pkg::REG_GAIN_D:  gain_d_nxt  = cfg_ch.data[mspe_pkg::GAIN_W-1:0];
        mspe_pkg::REG_MIN_PWM: min_pwm_nxt = cfg_ch.data[mspe_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end

    if (start) begin
      req_nxt = in_req;
      cmd_nxt = in_cmd;
    end

    if (out_ch.ready) oval_nxt = 1'b0;

    unique case (uop.op)
      mspe_pkg::OP_DECODE: begin
        upd_nxt = period_hit;
        unique case (req_r)
          mspe_pkg::REQ_EDGE: begin
            if (pulse_r != '1) pulse_nxt = pulse_r + COUNT_BITS'(1);
          end
          mspe_pkg::REQ_CMD: begin
            if (cmd_r > 0) begin
              dir_nxt    = mspe_pkg::DIR_FWD;
              target_nxt = cmd_r;
            end else if (cmd_r < 0) begin
              dir_nxt    = mspe_pkg::DIR_REV;
              target_nxt = cmd_neg[mspe_pkg::CMD_W-1:0];
            end else begin
              dir_nxt      = mspe_pkg::DIR_STOP;
              target_nxt   = '0;
              integral_nxt = '0;
            end
          end
          mspe_pkg::REQ_TICK: begin
            ms_nxt = period_hit ? '0 : ms_inc[mspe_pkg::MS_W-1:0];
          end
          default: ;
        endcase
      end
      mspe_pkg::OP_MUL_CNT: prod_nxt = $signed({1'b0, mul_a}) * mul_b;
      mspe_pkg::OP_MUL_DEN: begin
        rem_nxt  = NUM_W'(prod_r[COUNT_BITS+15:0]) << RPM_FRAC_BITS;
        prod_nxt = $signed({1'b0, mul_a}) * mul_b;
      end
      mspe_pkg::OP_LD_DEN: begin
        dsh_nxt = DSH_W'(prod_r[mspe_pkg::DEN_W-1:0]) << mspe_pkg::RPM_W;
        quo_nxt = '0;
      end
      mspe_pkg::OP_DIV_SAT: begin
        if (div_ge) begin
          quo_nxt = '1;
        end else begin
          dsh_nxt = dsh_r >> 1;
          cnt_nxt = 4'd15;
        end
      end
      mspe_pkg::OP_DIV_STEP: begin
        if (div_ge) rem_nxt = NUM_W'(CMP_W'(rem_r) - CMP_W'(dsh_r));
        quo_nxt = {quo_r[mspe_pkg::RPM_W-2:0], div_ge};
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - 4'd1;
      end
      mspe_pkg::OP_SPEED: begin
        speed_nxt = quo_r;
        pulse_nxt = '0;
      end
      mspe_pkg::OP_ERR: err_nxt = $signed(tgt_sh - ERR_W'(speed_r));
      mspe_pkg::OP_INT_DER: begin
        integral_nxt = INT_W'(iclamp);
        der_nxt      = DER_W'(dclamp);
        prev_nxt     = err_r;
        prod_nxt     = $signed({1'b0, mul_a}) * mul_b;
        acc_nxt      = '0;
      end
      mspe_pkg::OP_MUL_I, mspe_pkg::OP_MUL_D: begin
        prod_nxt = $signed({1'b0, mul_a}) * mul_b;
        acc_nxt  = acc_r + ACC_W'(prod_r);
      end
      mspe_pkg::OP_ACC: acc_nxt = acc_r + ACC_W'(prod_r);
      mspe_pkg::OP_DUTY: begin
        if (dir_r != mspe_pkg::DIR_STOP) duty_nxt = duty_cap;
      end
      mspe_pkg::OP_EMIT: begin
        if (!out_busy) begin
          oval_nxt = 1'b1;
          opwm_nxt = (dir_r != mspe_pkg::DIR_STOP) ? duty_r : '0;
          ofwd_nxt = (dir_r == mspe_pkg::DIR_FWD);
          orev_nxt = (dir_r == mspe_pkg::DIR_REV);
          orpm_nxt = speed_r;
          oupd_nxt = upd_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= mspe_pkg::RST_PERIOD;
      ppr_r      <= mspe_pkg::RST_PPR;
      gain_p_r   <= mspe_pkg::RST_GAIN_P;
      gain_i_r   <= mspe_pkg::RST_GAIN_I;
      gain_d_r   <= mspe_pkg::RST_GAIN_D;
      min_pwm_r  <= mspe_pkg::RST_MIN_PWM;
      pulse_r    <= '0;
      ms_r       <= '0;
      speed_r    <= '0;
      integral_r <= '0;
      prev_r     <= '0;
      duty_r     <= '0;
      target_r   <= '0;
      dir_r      <= mspe_pkg::DIR_STOP;
      oval_r     <= 1'b0;
    end else begin
      period_r   <= period_nxt;
      ppr_r      <= ppr_nxt;
      gain_p_r   <= gain_p_nxt;
      gain_i_r   <= gain_i_nxt;
      gain_d_r   <= gain_d_nxt;
      min_pwm_r  <= min_pwm_nxt;
      pulse_r    <= pulse_nxt;
      ms_r       <= ms_nxt;
      speed_r    <= speed_nxt;
      integral_r <= integral_nxt;
      prev_r     <= prev_nxt;
      duty_r     <= duty_nxt;
      target_r   <= target_nxt;
      dir_r      <= dir_nxt;
      oval_r     <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    cmd_r  <= cmd_nxt;
    upd_r  <= upd_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    err_r  <= err_nxt;
    der_r  <= der_nxt;
    opwm_r <= opwm_nxt;
    ofwd_r <= ofwd_nxt;
    orev_r <= orev_nxt;
    orpm_r <= orpm_nxt;
    oupd_r <= oupd_nxt;
  end

endmodule

@@ design/motor_speed_pid_encoder_core.sv @@
// ----------------------------------------------------------------------------
// motor_speed_pid_encoder_core : encoder speed measurement and PID duty loop
// Counts encoder edges, measures RPM once per period and runs a PID update.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake       payload
//  in_ch     in    valid / ready   req_type[1:0], speed_cmd[7:0] signed
//  out_ch    out   valid / ready   pwm_duty, dir_forward, dir_reverse,
//                                  measured_rpm[15:0], loop_updated
//  cfg_ch    in    valid / ready   index[2:0], data[15:0]
//
//  An encoder edge, a speed command or a tick that does not close the period
//  runs only the decode and emit steps after acceptance. A tick that closes
//  the period runs the whole microprogram: 14 steps plus 15 extra passes of
//  the divide step, or fewer when the speed saturates and the divide is
//  skipped, bound by the single shared multiplier and the one-bit-per-cycle
//  restoring divider.
//  in_ch.ready is high whenever the sequencer is idle; a finished result sits
//  in the output register, so the next transaction can be taken while it
//  waits. The emit step holds only if the previous result is still pending.
//  Reset (rst_n low, synchronous) loads the register defaults and clears
//  the loop state. cfg_ch is always ready.
//
module motor_speed_pid_encoder_core #(
  parameter int COUNT_BITS    = 16,
  parameter int RPM_FRAC_BITS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  mspe_in_if.sink      in_ch,
  mspe_out_if.source   out_ch,
  mspe_cfg_if.sink     cfg_ch
);

  mspe_pkg::ctrl_t uop;
  mspe_pkg::stat_t stat;
  logic            busy;
  logic            start;

  // Take a new request only while no program is running
  assign in_ch.ready = !busy;
  assign start       = in_ch.valid && in_ch.ready;

  // Sequencer: step counter and control ROM
  mspe_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .uop   (uop),
    .busy  (busy)
  );

  // Datapath: config, loop state, multiplier, divider, output register
  mspe_dp #(
    .COUNT_BITS    (COUNT_BITS),
    .RPM_FRAC_BITS (RPM_FRAC_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_req (in_ch.req_type),
    .in_cmd (in_ch.speed_cmd),
    .uop    (uop),
    .stat   (stat),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  // One request at a time: an accepted transaction drops ready next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ch.ready)
    else $error("request accepted while a program was still running");

  // Direction lines never both high
  a_dir_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.dir_forward && out_ch.dir_reverse))
    else $error("both direction lines high");

  // Nonzero duty only while a direction is driven
  a_duty_needs_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.pwm_duty != 8'd0)) |->
      (out_ch.dir_forward || out_ch.dir_reverse))
    else $error("duty applied while stopped");

endmodule
